FILE: rtl/rmst_pkg.sv
// rmst_pkg: shared types and constants of the range minimum segment tree
// no dependencies; imported by rmst_ctrl and range_min_segment_tree
package rmst_pkg;

    // item field widths
    localparam int IDX_W  = 11;
    localparam int DATA_W = 32;

    // operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // empty node marker, 2^30
    localparam data_t EMPTY_MARK = 32'sd1073741824;

    // finished query result from the sequencer to the output register
    typedef struct packed {
        logic  valid;
        data_t data;
    } res_t;

endpackage

FILE: rtl/range_min_segment_tree.sv
// range_min_segment_tree: top level of the range minimum segment tree
// depends on rmst_pkg, rmst_ram and rmst_ctrl
//
// Input channel (in_valid/in_ready) takes one item: operation selects a leaf
// update (lower leaf first_index to min of its value and value, no result) or
// a range minimum query over leaves [first_index, end_index) that gives one
// minimum item on the output channel (out_valid/out_ready). Empty ranges and
// never-lowered leaves read as 2^30.
// After reset the block sweeps all 2*LEAVES tree nodes to 2^30, one node a
// cycle, with in_ready low.
// The node ram has one read and one write port, which sets the timing. An
// update reads the leaf, writes the lowered leaf while it fetches the sibling,
// then writes each parent up to the root, one tree level a cycle; a query walks
// both bounds up the tree and reads and folds each boundary node; an
// out-of-range update is accepted and dropped, and an empty query goes straight
// to its result. in_ready is high only while the sequencer is idle.
// A finished result sits in an output register; a new item is accepted while
// it waits, and a following query holds its result until out_ready frees
// the register.
module range_min_segment_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [rmst_pkg::IDX_W-1:0] first_index,
    input  logic [rmst_pkg::IDX_W-1:0] end_index,
    input  rmst_pkg::data_t            value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rmst_pkg::data_t            minimum
);

    import rmst_pkg::*;

    localparam int NW = $clog2(2*LEAVES);

    logic          mem_we, mem_re;
    logic [NW-1:0] mem_waddr, mem_raddr;
    data_t         mem_wdata, mem_rdata;
    res_t          res;
    logic          res_ready;

    logic          out_valid_reg, out_valid_next;
    data_t         minimum_reg, minimum_next;

    rmst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2*LEAVES)
    ) u_nodes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rmst_ctrl #(
        .LEAVES (LEAVES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .first_index (first_index),
        .end_index   (end_index),
        .value       (value),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .res         (res),
        .res_ready   (res_ready)
    );

    // output register, free when empty or being taken
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        minimum_next   = minimum_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            minimum_next   = res.data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minimum_reg <= minimum_next;
    end

    assign out_valid = out_valid_reg;
    assign minimum   = minimum_reg;

endmodule

FILE: rtl/rmst_ram.sv
// rmst_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rmst_ctrl.sv
// rmst_ctrl: sequencer of the segment tree with one shared signed minimum unit
// depends on rmst_pkg; drives the node ram ports and hands query results out
module rmst_ctrl #(
    parameter int LEAVES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [rmst_pkg::IDX_W-1:0]         first_index,
    input  logic [rmst_pkg::IDX_W-1:0]         end_index,
    input  rmst_pkg::data_t                    value,
    output logic                               mem_we,
    output logic [$clog2(2*LEAVES)-1:0]        mem_waddr,
    output rmst_pkg::data_t                    mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(2*LEAVES)-1:0]        mem_raddr,
    input  rmst_pkg::data_t                    mem_rdata,
    output rmst_pkg::res_t                     res,
    input  logic                               res_ready
);

    import rmst_pkg::*;

    // node address width, walk counter width, index compare width
    localparam int NW = $clog2(2*LEAVES);
    localparam int CW = NW + 1;
    localparam int KW = (NW > IDX_W) ? NW + 1 : IDX_W + 1;

    localparam logic [KW-1:0] LEAVES_K  = KW'(LEAVES);
    localparam logic [NW-1:0] LAST_NODE = NW'(2*LEAVES - 1);
    localparam logic [NW-1:0] SIB_MASK  = NW'(1);
    localparam logic [CW-1:0] ROOT      = CW'(1);

    // sequencer states
    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ULEAF_RD = 3'd2;
    localparam logic [2:0] S_ULEAF_WR = 3'd3;
    localparam logic [2:0] S_UUP      = 3'd4;
    localparam logic [2:0] S_QLOOP    = 3'd5;
    localparam logic [2:0] S_QDONE    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] node_reg, node_next;
    logic [CW-1:0] rnode_reg, rnode_next;
    logic          pend_reg, pend_next;
    data_t         acc_reg, acc_next;
    data_t         val_reg, val_next;

    data_t         min_a, min_b, min_y;
    logic [KW-1:0] first_k, end_k, end_clamp;
    logic          q_empty, u_in_range;
    logic [CW-1:0] parent, rnode_dec;

    // shared signed minimum unit
    assign min_y = (min_a < min_b) ? min_a : min_b;

    // index checks on the incoming item
    assign first_k    = KW'(first_index);
    assign end_k      = KW'(end_index);
    assign end_clamp  = (end_k > LEAVES_K) ? LEAVES_K : end_k;
    assign q_empty    = (first_k >= end_clamp);
    assign u_in_range = (first_k < LEAVES_K);

    assign parent    = node_reg >> 1;
    assign rnode_dec = rnode_reg - CW'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        rnode_next = rnode_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        val_next   = val_reg;
        min_a      = acc_reg;
        min_b      = mem_rdata;
        mem_we     = 1'b0;
        mem_waddr  = node_reg[NW-1:0];
        mem_wdata  = min_y;
        mem_re     = 1'b0;
        mem_raddr  = node_reg[NW-1:0];
        in_ready   = 1'b0;
        res.valid  = 1'b0;
        res.data   = acc_reg;
        case (state_reg)
            S_CLEAR:
            begin
                // sweep every node to the empty marker
                mem_we    = 1'b1;
                mem_wdata = EMPTY_MARK;
                node_next = node_reg + CW'(1);
                if (node_reg[NW-1:0] == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_QUERY)
                    begin
                        acc_next  = EMPTY_MARK;
                        pend_next = 1'b0;
                        if (q_empty)
                        begin
                            state_next = S_QDONE;
                        end
                        else
                        begin
                            node_next  = CW'(first_k + LEAVES_K);
                            rnode_next = CW'(end_clamp + LEAVES_K);
                            state_next = S_QLOOP;
                        end
                    end
                    else if (u_in_range)
                    begin
                        val_next   = value;
                        node_next  = CW'(first_k + LEAVES_K);
                        state_next = S_ULEAF_RD;
                    end
                end
            end
            S_ULEAF_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_ULEAF_WR;
            end
            S_ULEAF_WR:
            begin
                // lower the leaf, fetch its sibling
                min_a      = val_reg;
                mem_we     = 1'b1;
                acc_next   = min_y;
                mem_re     = 1'b1;
                mem_raddr  = node_reg[NW-1:0] ^ SIB_MASK;
                state_next = S_UUP;
            end
            S_UUP:
            begin
                // parent takes min of this node and its sibling
                mem_we    = 1'b1;
                mem_waddr = parent[NW-1:0];
                acc_next  = min_y;
                node_next = parent;
                if (parent == ROOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent[NW-1:0] ^ SIB_MASK;
                end
            end
            S_QLOOP:
            begin
                // fold the node fetched last cycle, then one walk step
                acc_next  = pend_reg ? min_y : acc_reg;
                pend_next = 1'b0;
                if (node_reg >= rnode_reg)
                begin
                    state_next = S_QDONE;
                end
                else if (node_reg[0])
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    node_next = node_reg + CW'(1);
                end
                else if (rnode_reg[0])
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rnode_dec[NW-1:0];
                    pend_next  = 1'b1;
                    rnode_next = rnode_dec;
                end
                else
                begin
                    node_next  = node_reg >> 1;
                    rnode_next = rnode_reg >> 1;
                end
            end
            S_QDONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_reg  <= '0;
            rnode_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            rnode_reg <= rnode_next;
            pend_reg  <= pend_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        val_reg <= val_next;
    end

endmodule
